// File: rtl/seam_graph_edge_weights_assert.svh
// assertion macros for the seam edge weight block
`ifndef SEAM_GRAPH_EDGE_WEIGHTS_ASSERT_SVH
`define SEAM_GRAPH_EDGE_WEIGHTS_ASSERT_SVH

// condition and consequence in the same cycle
`define SGEW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define SGEW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sgew_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgew_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int FRAC_BITS    = 8;
    localparam int HEIGHT_LIMIT = 2048;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int CFG_W  = 12;
    localparam int POS_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
    localparam int WT_W   = 24;
    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int GRAD_W = 15;
    localparam int GSUM_W = GRAD_W + 1;
    localparam int GRAD_FRAC = 4;
    localparam int GRAD_ONE  = 1 << GRAD_FRAC;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int SSUM_W = SQ_W + 2;
    localparam int RAD_W  = SSUM_W + 2 * FRAC_BITS;
    localparam int DIST_W = RAD_W / 2;
    localparam int NUM_W  = DIST_W + 1;
    localparam int DEN_W  = GSUM_W + 2;
    localparam int DIVD_W = NUM_W + GRAD_FRAC;
    localparam int REM_W  = (DIST_W + 1 > DEN_W) ? DIST_W + 1 : DEN_W;
    localparam int CAND_W = REM_W + 2;
    localparam int OPND_W = (RAD_W > DIVD_W) ? RAD_W : DIVD_W;
    localparam int ACC_W  = (DIST_W > DIVD_W) ? DIST_W : DIVD_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int CNT_W = $clog2(((SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS) + 1);

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_COST_MODE      = 3'd0;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd1;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_TERMINAL_COST  = 3'd3;
    localparam logic [2:0] REG_REGION_PENALTY = 3'd4;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = CFG_W'(2048);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = CFG_W'(2048);
    localparam logic [WT_W-1:0]  RST_TERMINAL_COST  = WT_W'(2560000);
    localparam logic [WT_W-1:0]  RST_REGION_PENALTY = WT_W'(256000);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              ok;
        logic [GSUM_W-1:0] grad;
    } t_pix_entry;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_unit_op;

    typedef struct packed {
        logic              start;
        t_unit_op          op;
        logic [OPND_W-1:0] opnd;
        logic [DEN_W-1:0]  divisor;
    } t_unit_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQDIFF,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_LEFT_GO,
        S_LEFT_WAIT,
        S_UP_GO,
        S_UP_WAIT,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

// File: rtl/seam_graph_edge_weights.sv
`timescale 1ns / 1ps
`default_nettype none
// Graph-cut seam edge weights: one pixel pair is taken per transfer in raster order and
// one result transfer follows, carrying both terminal weights and the weights of the edges
// to the left and upper neighbours (zero where the edge does not exist). A pixel occupies
// the block from its input transfer until its result is registered; o_in_stall stays high
// meanwhile. The time is set by a single shared trial-subtract unit that computes the colour
// distance square root (17 steps) and, in gradient mode, one 22-step restoring division per
// existing edge; stalls on the output side lengthen it further. The previous row is kept in a
// 2048 x 34 single-port memory that needs no clearing pass after reset. Configuration is
// written over the APB port; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module seam_graph_edge_weights (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [sgew_pkg::APB_AW-1:0]    paddr,
    input  wire  [sgew_pkg::APB_DW-1:0]    pwdata,
    output logic [sgew_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [sgew_pkg::CH_W-1:0]      i_first_ch0,
    input  wire  [sgew_pkg::CH_W-1:0]      i_first_ch1,
    input  wire  [sgew_pkg::CH_W-1:0]      i_first_ch2,
    input  wire  [sgew_pkg::CH_W-1:0]      i_second_ch0,
    input  wire  [sgew_pkg::CH_W-1:0]      i_second_ch1,
    input  wire  [sgew_pkg::CH_W-1:0]      i_second_ch2,
    input  wire                            i_first_mask,
    input  wire                            i_second_mask,
    input  wire  [sgew_pkg::GRAD_W-1:0]    i_first_grad_h,
    input  wire  [sgew_pkg::GRAD_W-1:0]    i_second_grad_h,
    input  wire  [sgew_pkg::GRAD_W-1:0]    i_first_grad_v,
    input  wire  [sgew_pkg::GRAD_W-1:0]    i_second_grad_v,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [sgew_pkg::WT_W-1:0]      o_source_weight,
    output logic [sgew_pkg::WT_W-1:0]      o_sink_weight,
    output logic                           o_left_valid,
    output logic [sgew_pkg::WT_W-1:0]      o_left_weight,
    output logic                           o_up_valid,
    output logic [sgew_pkg::WT_W-1:0]      o_up_weight,
    output logic                           o_frame_end
);
    import sgew_pkg::*;

    function automatic logic [WT_W-1:0] edge_cost(
        input logic [NUM_W-1:0] q,
        input logic             ok,
        input logic [WT_W-1:0]  pen
    );
        logic [WT_W:0] sum;
        sum = (WT_W+1)'(q) + (WT_W+1)'(ONE) + (ok ? '0 : (WT_W+1)'(pen));
        return sum[WT_W] ? '1 : sum[WT_W-1:0];
    endfunction

    // configuration
    logic             r_cost_mode;
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [WT_W-1:0]  r_terminal_cost;
    logic [WT_W-1:0]  r_region_penalty;

    // control
    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_k;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_out_valid;

    // pixel payload
    logic [CH_W-1:0]   r_ch_a [3];
    logic [CH_W-1:0]   r_ch_b [3];
    logic              r_m1;
    logic              r_m2;
    logic [GSUM_W-1:0] r_hgrad;
    logic [GSUM_W-1:0] r_vgrad;
    logic [SSUM_W-1:0] r_ssum;
    logic [DIST_W-1:0] r_dist;
    logic [NUM_W-1:0]  r_q_left;
    logic [NUM_W-1:0]  r_q_up;
    t_pix_entry        r_prev;
    t_pix_entry        r_rd_entry;
    t_pix_entry        row_mem [MAX_WIDTH];

    logic [WT_W-1:0] r_source_weight;
    logic [WT_W-1:0] r_sink_weight;
    logic            r_left_valid;
    logic [WT_W-1:0] r_left_weight;
    logic            r_up_valid;
    logic [WT_W-1:0] r_up_weight;
    logic            r_frame_end;

    logic             cfg_wr;
    logic             in_xfer;
    logic             out_free;
    logic             fire;
    logic             mem_re;
    logic             left_has;
    logic             up_has;
    logic             left_div;
    logic             up_div;
    logic [CH_W-1:0]  ch_a;
    logic [CH_W-1:0]  ch_b;
    logic [CH_W-1:0]  ch_diff;
    logic [SQ_W-1:0]  ch_sq;
    logic [NUM_W-1:0] num_left;
    logic [NUM_W-1:0] num_up;
    logic [DEN_W-1:0] den_left;
    logic [DEN_W-1:0] den_up;
    logic [POS_W-1:0] width_eff;
    logic [POS_W-1:0] height_eff;
    logic             last_col;
    logic             last_row;
    logic             cur_ok;
    t_pix_entry       cur_h;
    t_pix_entry       cur_v;
    t_unit_cmd        unit_cmd;
    t_unit_stat       unit_stat;
    logic [ACC_W-1:0] unit_result;

    sgew_iter_unit u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (unit_cmd),
        .o_stat   (unit_stat),
        .o_result (unit_result)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            REG_COST_MODE:      prdata = APB_DW'(r_cost_mode);
            REG_FRAME_WIDTH:    prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(r_frame_height);
            REG_TERMINAL_COST:  prdata = APB_DW'(r_terminal_cost);
            REG_REGION_PENALTY: prdata = APB_DW'(r_region_penalty);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_mode      <= 1'b1;
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_terminal_cost  <= RST_TERMINAL_COST;
            r_region_penalty <= RST_REGION_PENALTY;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_COST_MODE:      r_cost_mode      <= pwdata[0];
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= pwdata[CFG_W-1:0];
                REG_TERMINAL_COST:  r_terminal_cost  <= pwdata[WT_W-1:0];
                REG_REGION_PENALTY: r_region_penalty <= pwdata[WT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath terms
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign left_has = r_col != '0;
    assign up_has   = r_row != '0;
    assign left_div = r_cost_mode && left_has;
    assign up_div   = r_cost_mode && up_has;

    assign ch_a    = r_ch_a[r_k];
    assign ch_b    = r_ch_b[r_k];
    assign ch_diff = (ch_a > ch_b) ? ch_a - ch_b : ch_b - ch_a;
    assign ch_sq   = SQ_W'(ch_diff) * SQ_W'(ch_diff);

    assign num_left = NUM_W'(r_prev.distance) + NUM_W'(r_dist);
    assign num_up   = NUM_W'(r_rd_entry.distance) + NUM_W'(r_dist);
    assign den_left = DEN_W'(r_prev.grad) + DEN_W'(r_hgrad) + DEN_W'(GRAD_ONE);
    assign den_up   = DEN_W'(r_rd_entry.grad) + DEN_W'(r_vgrad) + DEN_W'(GRAD_ONE);

    assign cur_ok         = r_m1 && r_m2;
    assign cur_h.distance = r_dist;
    assign cur_h.ok       = cur_ok;
    assign cur_h.grad     = r_hgrad;
    assign cur_v.distance = r_dist;
    assign cur_v.ok       = cur_ok;
    assign cur_v.grad     = r_vgrad;

    // zero acts as one, anything past the limit acts as the limit
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = POS_W'(1);
        end else if (POS_W'(r_frame_width) > POS_W'(MAX_WIDTH)) begin
            width_eff = POS_W'(MAX_WIDTH);
        end else begin
            width_eff = POS_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            height_eff = POS_W'(1);
        end else if (POS_W'(r_frame_height) > POS_W'(HEIGHT_LIMIT)) begin
            height_eff = POS_W'(HEIGHT_LIMIT);
        end else begin
            height_eff = POS_W'(r_frame_height);
        end
    end

    assign last_col = POS_W'(r_col) + POS_W'(1) >= width_eff;
    assign last_row = POS_W'(r_row) + POS_W'(1) >= height_eff;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SQDIFF;
            S_SQDIFF:    if (r_k == 2'd2) n_state = S_ROOT_GO;
            S_ROOT_GO:   n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (unit_stat.done) n_state = S_LEFT_GO;
            S_LEFT_GO:   n_state = left_div ? S_LEFT_WAIT : S_UP_GO;
            S_LEFT_WAIT: if (unit_stat.done) n_state = S_UP_GO;
            S_UP_GO:     n_state = up_div ? S_UP_WAIT : S_FINISH;
            S_UP_WAIT:   if (unit_stat.done) n_state = S_FINISH;
            S_FINISH:    if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = 1'b1;
        mem_re           = 1'b0;
        fire             = 1'b0;
        unit_cmd.start   = 1'b0;
        unit_cmd.op      = OP_SQRT;
        unit_cmd.opnd    = OPND_W'(RAD_W'(r_ssum) << (2 * FRAC_BITS)) << (OPND_W - RAD_W);
        unit_cmd.divisor = den_left;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = i_in_valid;
            end
            S_ROOT_GO: begin
                unit_cmd.start = 1'b1;
            end
            S_LEFT_GO: begin
                unit_cmd.start   = left_div;
                unit_cmd.op      = OP_DIV;
                unit_cmd.opnd    = OPND_W'(DIVD_W'(num_left) << GRAD_FRAC) << (OPND_W - DIVD_W);
                unit_cmd.divisor = den_left;
            end
            S_UP_GO: begin
                unit_cmd.start   = up_div;
                unit_cmd.op      = OP_DIV;
                unit_cmd.opnd    = OPND_W'(DIVD_W'(num_up) << GRAD_FRAC) << (OPND_W - DIVD_W);
                unit_cmd.divisor = den_up;
            end
            S_FINISH: begin
                fire = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= 2'd0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_k <= 2'd0;
            end else if (r_state == S_SQDIFF) begin
                r_k <= r_k + 2'd1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch_a[0] <= i_first_ch0;
            r_ch_a[1] <= i_first_ch1;
            r_ch_a[2] <= i_first_ch2;
            r_ch_b[0] <= i_second_ch0;
            r_ch_b[1] <= i_second_ch1;
            r_ch_b[2] <= i_second_ch2;
            r_m1      <= i_first_mask;
            r_m2      <= i_second_mask;
            r_hgrad   <= GSUM_W'(i_first_grad_h) + GSUM_W'(i_second_grad_h);
            r_vgrad   <= GSUM_W'(i_first_grad_v) + GSUM_W'(i_second_grad_v);
            r_ssum    <= '0;
        end else if (r_state == S_SQDIFF) begin
            r_ssum <= r_ssum + SSUM_W'(ch_sq);
        end
        if (r_state == S_ROOT_WAIT && unit_stat.done) begin
            r_dist <= unit_result[DIST_W-1:0];
        end
        // colour-only mode, or an absent edge, takes the distance sum as it is
        if (r_state == S_LEFT_GO && !left_div) begin
            r_q_left <= num_left;
        end else if (r_state == S_LEFT_WAIT && unit_stat.done) begin
            r_q_left <= unit_result[NUM_W-1:0];
        end
        if (r_state == S_UP_GO && !up_div) begin
            r_q_up <= num_up;
        end else if (r_state == S_UP_WAIT && unit_stat.done) begin
            r_q_up <= unit_result[NUM_W-1:0];
        end
        if (fire) begin
            r_prev          <= cur_h;
            r_source_weight <= r_m1 ? r_terminal_cost : '0;
            r_sink_weight   <= r_m2 ? r_terminal_cost : '0;
            r_left_valid    <= left_has;
            r_left_weight   <= left_has ?
                               edge_cost(r_q_left, r_prev.ok && cur_ok, r_region_penalty) : '0;
            r_up_valid      <= up_has;
            r_up_weight     <= up_has ?
                               edge_cost(r_q_up, r_rd_entry.ok && cur_ok, r_region_penalty) : '0;
            r_frame_end     <= last_col && last_row;
        end
    end

    // previous row store, read at transfer time and written back when the pixel retires
    always_ff @(posedge i_clk) begin
        if (fire) begin
            row_mem[r_col] <= cur_v;
        end
        if (mem_re) begin
            r_rd_entry <= row_mem[r_col];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source_weight = r_source_weight;
    assign o_sink_weight   = r_sink_weight;
    assign o_left_valid    = r_left_valid;
    assign o_left_weight   = r_left_weight;
    assign o_up_valid      = r_up_valid;
    assign o_up_weight     = r_up_weight;
    assign o_frame_end     = r_frame_end;

endmodule
`default_nettype wire

// File: rtl/sgew_iter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module sgew_iter_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sgew_pkg::t_unit_cmd           i_cmd,
    output sgew_pkg::t_unit_stat          o_stat,
    output logic [sgew_pkg::ACC_W-1:0]    o_result
);
    import sgew_pkg::*;

    t_unit_op          r_op;
    logic [REM_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_acc;
    logic [OPND_W-1:0] r_opnd;
    logic [DEN_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] trial;
    logic [CAND_W-1:0] diff;
    logic              ge;
    logic [REM_W-1:0]  n_rem;
    logic [ACC_W-1:0]  n_acc;
    logic [OPND_W-1:0] n_opnd;

    // one trial subtract per cycle, shared by root and quotient recurrences
    always_comb begin
        unique case (r_op)
            OP_SQRT: begin
                cand   = {r_rem, r_opnd[OPND_W-1 -: 2]};
                trial  = CAND_W'({r_acc[DIST_W-1:0], 2'b01});
                n_opnd = r_opnd << 2;
            end
            OP_DIV: begin
                cand   = CAND_W'({r_rem, r_opnd[OPND_W-1]});
                trial  = CAND_W'(r_div);
                n_opnd = r_opnd << 1;
            end
            default: begin
                cand   = '0;
                trial  = '0;
                n_opnd = r_opnd;
            end
        endcase
        ge    = cand >= trial;
        diff  = cand - trial;
        n_rem = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
        n_acc = {r_acc[ACC_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_rem  <= '0;
            r_acc  <= '0;
            r_opnd <= i_cmd.opnd;
            r_div  <= i_cmd.divisor;
            r_cnt  <= (i_cmd.op == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_opnd <= n_opnd;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule
`default_nettype wire

// File: rtl/sgew_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "seam_graph_edge_weights_assert.svh"
module sgew_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire                          o_left_valid,
    input wire [sgew_pkg::WT_W-1:0]     o_left_weight,
    input wire                          o_up_valid,
    input wire [sgew_pkg::WT_W-1:0]     o_up_weight
);
    import sgew_pkg::*;

    `SGEW_ASSERT_NEXT(a_busy_after_in, i_in_valid && !o_in_stall, o_in_stall, "pixel transfer not followed by busy")
    `SGEW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_left_weight) && $stable(o_up_weight), "stalled result changed")
    `SGEW_ASSERT_NOW(a_left_absent, o_out_valid && !o_left_valid, o_left_weight == '0, "absent left edge has weight")
    `SGEW_ASSERT_NOW(a_up_absent, o_out_valid && !o_up_valid, o_up_weight == '0, "absent upper edge has weight")
    `SGEW_ASSERT_NOW(a_left_min, o_out_valid && o_left_valid, o_left_weight >= WT_W'(ONE), "left edge below unit cost")

endmodule

bind seam_graph_edge_weights sgew_checker u_sgew_checker (.*);
`default_nettype wire

// File: dv/seam_graph_edge_weights_test.sv
`timescale 1ns / 1ps
module seam_graph_edge_weights_test;
    import sgew_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]   first_ch0;
        logic [CH_W-1:0]   first_ch1;
        logic [CH_W-1:0]   first_ch2;
        logic [CH_W-1:0]   second_ch0;
        logic [CH_W-1:0]   second_ch1;
        logic [CH_W-1:0]   second_ch2;
        logic              first_mask;
        logic              second_mask;
        logic [GRAD_W-1:0] first_grad_h;
        logic [GRAD_W-1:0] second_grad_h;
        logic [GRAD_W-1:0] first_grad_v;
        logic [GRAD_W-1:0] second_grad_v;
    } pixel_t;

    typedef struct packed {
        logic [WT_W-1:0] source_weight;
        logic [WT_W-1:0] sink_weight;
        logic            left_valid;
        logic [WT_W-1:0] left_weight;
        logic            up_valid;
        logic [WT_W-1:0] up_weight;
        logic            frame_end;
    } weights_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    pixel_t pix_in = '0;

    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [WT_W-1:0] o_source_weight;
    logic [WT_W-1:0] o_sink_weight;
    logic            o_left_valid;
    logic [WT_W-1:0] o_left_weight;
    logic            o_up_valid;
    logic [WT_W-1:0] o_up_weight;
    logic            o_frame_end;

    seam_graph_edge_weights dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_first_ch0     (pix_in.first_ch0),
        .i_first_ch1     (pix_in.first_ch1),
        .i_first_ch2     (pix_in.first_ch2),
        .i_second_ch0    (pix_in.second_ch0),
        .i_second_ch1    (pix_in.second_ch1),
        .i_second_ch2    (pix_in.second_ch2),
        .i_first_mask    (pix_in.first_mask),
        .i_second_mask   (pix_in.second_mask),
        .i_first_grad_h  (pix_in.first_grad_h),
        .i_second_grad_h (pix_in.second_grad_h),
        .i_first_grad_v  (pix_in.first_grad_v),
        .i_second_grad_v (pix_in.second_grad_v),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_source_weight (o_source_weight),
        .o_sink_weight   (o_sink_weight),
        .o_left_valid    (o_left_valid),
        .o_left_weight   (o_left_weight),
        .o_up_valid      (o_up_valid),
        .o_up_weight     (o_up_weight),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register shadow
    logic            cfg_mode = 1'b1;
    logic [CFG_W-1:0] cfg_width = RST_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    logic [WT_W-1:0] cfg_terminal = RST_TERMINAL_COST;
    logic [WT_W-1:0] cfg_penalty = RST_REGION_PENALTY;

    // edge predictor state
    t_pix_entry row_mem [MAX_WIDTH];
    bit         row_written [MAX_WIDTH];
    t_pix_entry prev_entry;
    int         col_pos = 0;
    int         row_pos = 0;

    weights_t pending_weights [$];

    int  error_count = 0;
    int  pixels_sent = 0;
    int  results_seen = 0;
    int  frames_seen = 0;
    int  reg_writes = 0;
    int  burst_left = 0;
    bit  calm = 1'b0;
    int  stall_run = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch: %s at result %0d: got 0x%0h, want 0x%0h",
                     what, results_seen, got, want);
    endtask

    function automatic int clamp_size(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic logic [DIST_W-1:0] color_distance(input pixel_t p);
        int          d0, d1, d2;
        logic [63:0] v, root, bitv;
        d0 = int'(p.first_ch0) - int'(p.second_ch0);
        d1 = int'(p.first_ch1) - int'(p.second_ch1);
        d2 = int'(p.first_ch2) - int'(p.second_ch2);
        v = 64'(d0 * d0 + d1 * d1 + d2 * d2) << (2 * FRAC_BITS);
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        // digit-by-digit truncated square root
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root[DIST_W-1:0];
    endfunction

    function automatic logic [WT_W-1:0] edge_cost(input t_pix_entry a, input t_pix_entry b);
        logic [63:0] num, den, w;
        num = 64'(a.distance) + 64'(b.distance);
        if (cfg_mode) begin
            den = 64'(a.grad) + 64'(b.grad) + 64'(GRAD_ONE);
            w   = (num * GRAD_ONE) / den;
        end else begin
            w = num;
        end
        w = w + 64'(ONE);
        if (!(a.ok && b.ok))
            w = w + 64'(cfg_penalty);
        return (w > 64'hFF_FFFF) ? '1 : w[WT_W-1:0];
    endfunction

    function automatic weights_t predict_weights(input pixel_t p);
        t_pix_entry cur_h, cur_v;
        weights_t   r;
        bit         last_col, last_row;
        cur_h.distance = color_distance(p);
        cur_h.ok       = p.first_mask & p.second_mask;
        cur_h.grad     = {1'b0, p.first_grad_h} + {1'b0, p.second_grad_h};
        cur_v          = cur_h;
        cur_v.grad     = {1'b0, p.first_grad_v} + {1'b0, p.second_grad_v};
        r = '0;
        r.source_weight = p.first_mask ? cfg_terminal : '0;
        r.sink_weight   = p.second_mask ? cfg_terminal : '0;
        if (col_pos > 0) begin
            r.left_valid  = 1'b1;
            r.left_weight = edge_cost(prev_entry, cur_h);
        end
        if (row_pos > 0) begin
            r.up_valid  = 1'b1;
            r.up_weight = edge_cost(row_mem[col_pos], cur_v);
        end
        row_mem[col_pos]     = cur_v;
        row_written[col_pos] = 1'b1;
        prev_entry           = cur_h;
        last_col    = col_pos + 1 >= clamp_size(cfg_width);
        last_row    = row_pos + 1 >= clamp_size(cfg_height);
        r.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    // a new width must not lead an upper edge onto a column never written
    function automatic bit width_is_safe(input int wd);
        int k, stop;
        if (row_pos == 0)
            return 1'b1;
        stop = (wd > col_pos + 1) ? wd : col_pos + 1;
        for (k = col_pos; k < stop; k++)
            if (!row_written[k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic read_reg(input logic [2:0] idx, input logic [31:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        want = '0;
        case (idx)
            REG_COST_MODE: begin
                cfg_mode = value[0];
                want[0]  = value[0];
            end
            REG_FRAME_WIDTH: begin
                cfg_width         = value[CFG_W-1:0];
                want[CFG_W-1:0]   = value[CFG_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
                cfg_height        = value[CFG_W-1:0];
                want[CFG_W-1:0]   = value[CFG_W-1:0];
            end
            REG_TERMINAL_COST: begin
                cfg_terminal      = value[WT_W-1:0];
                want[WT_W-1:0]    = value[WT_W-1:0];
            end
            REG_REGION_PENALTY: begin
                cfg_penalty       = value[WT_W-1:0];
                want[WT_W-1:0]    = value[WT_W-1:0];
            end
            default: ;
        endcase
        reg_writes++;
        read_reg(idx, want);
    endtask

    task automatic send_pixel(input pixel_t p);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            if (calm)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(10, 90);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        pix_in     = p;
        i_in_valid = 1'b1;
        pending_weights.push_back(predict_weights(p));
        pixels_sent++;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_weights.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic pixel_t make_pixel(input logic [23:0] first_rgb,
                                          input logic [23:0] second_rgb,
                                          input logic m1, input logic m2,
                                          input logic [GRAD_W-1:0] grad_h,
                                          input logic [GRAD_W-1:0] grad_v);
        pixel_t p;
        {p.first_ch0, p.first_ch1, p.first_ch2}    = first_rgb;
        {p.second_ch0, p.second_ch1, p.second_ch2} = second_rgb;
        p.first_mask    = m1;
        p.second_mask   = m2;
        p.first_grad_h  = grad_h;
        p.second_grad_h = grad_h;
        p.first_grad_v  = grad_v;
        p.second_grad_v = grad_v;
        return p;
    endfunction

    function automatic pixel_t random_pixel();
        logic [127:0] raw;
        pixel_t       p;
        raw = {$urandom, $urandom, $urandom, $urandom};
        p   = raw[$bits(pixel_t)-1:0];
        case ($urandom_range(0, 7))
            0: {p.second_ch0, p.second_ch1, p.second_ch2} =
                   {p.first_ch0, p.first_ch1, p.first_ch2};
            1: begin
                {p.first_ch0, p.first_ch1, p.first_ch2}    = '1;
                {p.second_ch0, p.second_ch1, p.second_ch2} = '0;
            end
            default: ;
        endcase
        p.first_mask  = ($urandom_range(0, 9) != 0);
        p.second_mask = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 5))
            0, 1: begin
                p.first_grad_h  = $urandom_range(0, 63);
                p.second_grad_h = $urandom_range(0, 63);
                p.first_grad_v  = $urandom_range(0, 63);
                p.second_grad_v = $urandom_range(0, 63);
            end
            2: begin
                p.first_grad_h  = '1;
                p.second_grad_h = '1;
                p.first_grad_v  = '1;
                p.second_grad_v = '1;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] random_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h00FF_FFFF;
            2: return $urandom_range(0, 4000);
            default: return {8'd0, 24'($urandom)};
        endcase
    endfunction

    // receiver stall pattern: alternating free and stalled runs of random length, held free while calm
    always @(negedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_run == 0) begin
            i_out_stall <= !i_out_stall;
            stall_run   <= i_out_stall ? $urandom_range(2, 30) : $urandom_range(0, 9);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        weights_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_weights.size() == 0) begin
                report_mismatch("result transfer with no pixel pending", 32'd0, 32'd0);
            end else begin
                want = pending_weights.pop_front();
                if (o_source_weight !== want.source_weight)
                    report_mismatch("source_weight", o_source_weight, want.source_weight);
                if (o_sink_weight !== want.sink_weight)
                    report_mismatch("sink_weight", o_sink_weight, want.sink_weight);
                if (o_left_valid !== want.left_valid)
                    report_mismatch("left_valid", o_left_valid, want.left_valid);
                if (o_left_weight !== want.left_weight)
                    report_mismatch("left_weight", o_left_weight, want.left_weight);
                if (o_up_valid !== want.up_valid)
                    report_mismatch("up_valid", o_up_valid, want.up_valid);
                if (o_up_weight !== want.up_weight)
                    report_mismatch("up_weight", o_up_weight, want.up_weight);
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
                if (want.frame_end)
                    frames_seen++;
            end
            results_seen++;
        end
    end

    task automatic test_reset_defaults();
        read_reg(REG_COST_MODE, 32'd1);
        read_reg(REG_FRAME_WIDTH, 32'(RST_FRAME_WIDTH));
        read_reg(REG_FRAME_HEIGHT, 32'(RST_FRAME_HEIGHT));
        read_reg(REG_TERMINAL_COST, 32'(RST_TERMINAL_COST));
        read_reg(REG_REGION_PENALTY, 32'(RST_REGION_PENALTY));
        send_pixel(make_pixel(24'h000000, 24'h000000, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '1, '1));
        send_pixel(make_pixel(24'h123456, 24'h654321, 1'b0, 1'b1, 15'h0123, 15'h4000));
        send_pixel(make_pixel(24'hA5A5A5, 24'h5A5A5A, 1'b0, 1'b0, 15'h7FF0, 15'h0001));
        wait_idle();
    endtask

    // max terminal cost and penalty push every masked edge into saturation
    task automatic test_saturation();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'd2);
        write_reg(REG_TERMINAL_COST, 32'h00FF_FFFF);
        write_reg(REG_REGION_PENALTY, 32'h00FF_FFFF);
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 1'b1, 1'b0, '1, '0));
        send_pixel(make_pixel(24'h808080, 24'h808080, 1'b0, 1'b1, '0, '1));
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b0, 1'b0, '1, '1));
        send_pixel(make_pixel(24'h010203, 24'hFEFDFC, 1'b1, 1'b1, 15'd1, 15'd1));
        send_pixel(make_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, '1, '0));
        wait_idle();
    endtask

    // zero sizes act as one; colour-only mode with zero costs
    task automatic test_size_clamp();
        write_reg(REG_COST_MODE, 32'd0);
        write_reg(REG_FRAME_WIDTH, 32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        write_reg(REG_TERMINAL_COST, 32'd0);
        write_reg(REG_REGION_PENALTY, 32'd0);
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '1, '1));
        send_pixel(make_pixel(24'h00FF00, 24'hFF00FF, 1'b0, 1'b1, '0, '0));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 32'd1);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'h000000, 24'hFFFFFF, 1'b1, 1'b1, '0, '1));
        send_pixel(make_pixel(24'h7F7F7F, 24'h807F7E, 1'b1, 1'b0, '1, '0));
        wait_idle();
    endtask

    // oversized registers clamp; shrinking the frame mid-row ends the row and frame
    task automatic test_midframe_change();
        write_reg(REG_FRAME_WIDTH, 32'd4095);
        write_reg(REG_FRAME_HEIGHT, 32'd4095);
        write_reg(REG_TERMINAL_COST, 32'd777);
        write_reg(REG_REGION_PENALTY, 32'd1000);
        send_pixel(make_pixel(24'h102030, 24'h302010, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'hFF0000, 24'h00FF00, 1'b0, 1'b1, '0, '0));
        send_pixel(make_pixel(24'h0000FF, 24'h0000FF, 1'b1, 1'b1, '1, '1));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 32'd2);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        send_pixel(make_pixel(24'hFFFFFF, 24'h000000, 1'b1, 1'b0, '1, '0));
        send_pixel(make_pixel(24'h000000, 24'h000000, 1'b1, 1'b1, '0, '0));
        send_pixel(make_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, '1, '1));
        wait_idle();
    endtask

    task automatic test_random_frames();
        int               sent, n, k;
        logic [CFG_W-1:0] wd, ht;
        sent = 0;
        while (sent < 700) begin
            calm = ($urandom_range(0, 4) == 0);
            write_reg(REG_COST_MODE, $urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0: wd = 0;
                1: wd = 4095;
                2: wd = MAX_WIDTH;
                3: wd = $urandom_range(9, 300);
                default: wd = $urandom_range(1, 8);
            endcase
            if (width_is_safe(clamp_size(wd)))
                write_reg(REG_FRAME_WIDTH, 32'(wd));
            case ($urandom_range(0, 15))
                0: ht = 0;
                1: ht = 4095;
                2: ht = $urandom_range(9, 2048);
                default: ht = $urandom_range(1, 8);
            endcase
            write_reg(REG_FRAME_HEIGHT, 32'(ht));
            write_reg(REG_TERMINAL_COST, random_weight());
            write_reg(REG_REGION_PENALTY, random_weight());
            n = $urandom_range(15, 50);
            for (k = 0; k < n; k++)
                send_pixel(random_pixel());
            sent += n;
            wait_idle();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_saturation();
        test_size_clamp();
        test_midframe_change();
        test_random_frames();
        wait_idle();
        repeat (100) @(negedge i_clk);
        $display("ran %0d pixel transfers and checked %0d result transfers over %0d frame ends",
                 pixels_sent, results_seen, frames_seen);
        $display("%0d register writes with readback, %0d mismatches", reg_writes, error_count);
        if (error_count == 0)
            $display("PASS seam_graph_edge_weights");
        else
            $display("FAIL seam_graph_edge_weights");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results still pending", pending_weights.size());
        $display("FAIL seam_graph_edge_weights");
        $finish;
    end

endmodule
